[rtl/rmq_pkg.sv]
// ----------------------------------------------------------------------------
// rmq_pkg: shared types and constants for the matrix-to-quaternion pipeline
// Holds fixed field widths, the per-cell payload struct and branch codes.
// ----------------------------------------------------------------------------
package rmq_pkg;

	localparam int ELEM_W = 16;

	// Branch codes reported with each result.
	localparam logic [1:0] BR_TRACE = 2'd0;
	localparam logic [1:0] BR_AX0   = 2'd1;
	localparam logic [1:0] BR_AX1   = 2'd2;
	localparam logic [1:0] BR_AX2   = 2'd3;

	// Sign/magnitude of an element sum or difference (fits in 17 bits).
	typedef struct packed {
		logic        neg;
		logic [16:0] mag;
	} term_t;

	// Control that rides along with each item through the cell rows.
	typedef struct packed {
		logic       vld;
		logic [1:0] branch;
		logic       degen;
	} tag_t;

endpackage

[rtl/rmq_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// rmq_sqrt_cell: one restoring square-root step
// Resolves one result bit per enabled cycle, passes remainder and root on.
// ----------------------------------------------------------------------------
module rmq_sqrt_cell #(
	parameter int RAD_W = 48,
	parameter int ROOT_W = 24,
	parameter int STEP = 0
) (
	input  logic              clk,
	input  logic              en,
	input  logic [RAD_W-1:0]  rem_in,
	input  logic [ROOT_W-1:0] root_in,
	output logic [RAD_W-1:0]  rem_out,
	output logic [ROOT_W-1:0] root_out
);
	localparam int BITPOS = ROOT_W - 1 - STEP;

	logic [RAD_W+1:0] trial;
	logic [RAD_W+1:0] cand;
	logic [RAD_W+1:0] rem_ext;

	// Test (2*root + bit) * bit against the remainder, with root already
	// holding the upper resolved bits in place.
	always_comb begin
		rem_ext = {2'b00, rem_in};
		cand    = ({{(RAD_W+2-ROOT_W){1'b0}}, root_in} << (BITPOS + 1))
			+ ({{(RAD_W+1){1'b0}}, 1'b1} << (2 * BITPOS));
		trial   = rem_ext - cand;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (rem_ext >= cand) begin
				rem_out  <= trial[RAD_W-1:0];
				root_out <= root_in | (ROOT_W'(1) << BITPOS);
			end else begin
				rem_out  <= rem_in;
				root_out <= root_in;
			end
		end
	end
endmodule

[rtl/rmq_div_cell.sv]
// ----------------------------------------------------------------------------
// rmq_div_cell: one restoring division step for three dividends at once
// Shares one divisor across the three scaled terms of an item.
// ----------------------------------------------------------------------------
module rmq_div_cell #(
	parameter int NUM_W = 48,
	parameter int DEN_W = 26,
	parameter int Q_W = 18,
	parameter int STEP = 0
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic [DEN_W-1:0]      den,
	input  logic [2:0][NUM_W-1:0] rem_in,
	input  logic [2:0][Q_W-1:0]   quo_in,
	output logic [2:0][NUM_W-1:0] rem_out,
	output logic [2:0][Q_W-1:0]   quo_out
);
	localparam int BITPOS = Q_W - 1 - STEP;

	logic [NUM_W+Q_W-1:0] sh;
	logic [2:0]           take;

	always_comb begin
		sh = {{Q_W{1'b0}}, {(NUM_W-DEN_W){1'b0}}, den} << BITPOS;
		for (int t = 0; t < 3; t++)
			take[t] = {{Q_W{1'b0}}, rem_in[t]} >= sh;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int t = 0; t < 3; t++) begin
				rem_out[t] <= take[t] ? rem_in[t] - sh[NUM_W-1:0] : rem_in[t];
				quo_out[t] <= take[t] ? (quo_in[t] | (Q_W'(1) << BITPOS)) : quo_in[t];
			end
		end
	end
endmodule

[rtl/rotation_matrix_to_quaternion_unit.sv]
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_unit: Shepperd matrix-to-quaternion pipeline
// Fixed-point rotation matrix in, saturated quaternion and branch out.
// ----------------------------------------------------------------------------
// One matrix is taken and one quaternion leaves per cycle while the output
// is not stalled. Stages are the input register, ROOT_W square-root cells
// (ROOT_W = (ARG_W + FRAC_BITS + 1) / 2, 17 at FRAC_BITS = 14), then
// Q_W = 18 divider cells, then the output register.
// A chain of square-root cells feeds a chain of divider cells, each cell
// resolving one bit per cycle. The whole chain advances when the output
// register is free or about to be taken, so a stall on the output holds every
// stage in place; input stall is the same hold signal. Branch selection
// (trace or largest diagonal) happens in the first stage, saturation in the
// last.
module rotation_matrix_to_quaternion_unit #(
	parameter int FRAC_BITS = 14
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [rmq_pkg::ELEM_W-1:0] m00,
	input  logic signed [rmq_pkg::ELEM_W-1:0] m01,
	input  logic signed [rmq_pkg::ELEM_W-1:0] m02,
	input  logic signed [rmq_pkg::ELEM_W-1:0] m10,
	input  logic signed [rmq_pkg::ELEM_W-1:0] m11,
	input  logic signed [rmq_pkg::ELEM_W-1:0] m12,
	input  logic signed [rmq_pkg::ELEM_W-1:0] m20,
	input  logic signed [rmq_pkg::ELEM_W-1:0] m21,
	input  logic signed [rmq_pkg::ELEM_W-1:0] m22,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [rmq_pkg::ELEM_W-1:0] qw,
	output logic signed [rmq_pkg::ELEM_W-1:0] qx,
	output logic signed [rmq_pkg::ELEM_W-1:0] qy,
	output logic signed [rmq_pkg::ELEM_W-1:0] qz,
	output logic [1:0]                  branch,
	output logic                        degenerate
);
	import rmq_pkg::*;

	// arg stays below 2^17 + 2^F, plus one sign bit; the radicand arg << F
	// needs ARG_W + F bits, root needs half of that.
	localparam int ARG_W  = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
	localparam int RAD_W  = 2 * (((ARG_W + FRAC_BITS) + 1) / 2);
	localparam int ROOT_W = RAD_W / 2;
	localparam int DEN_W  = ROOT_W + 1;
	localparam int Q_W    = 18;
	localparam int NUM_W  = 17 + FRAC_BITS + 1 + Q_W;
	localparam int NS     = ROOT_W;
	localparam int ND     = Q_W;

	logic adv;
	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	// ---------------- stage 1: branch select, root argument, terms ---------
	logic signed [17:0] tr, arg_d;
	logic signed [17:0] d0, d1, d2;
	logic [1:0]         ax;
	logic signed [ELEM_W-1:0] mii, mjj, mkk;

	function automatic term_t to_term(input logic signed [17:0] v);
		term_t t;
		t.neg = v[17];
		t.mag = v[17] ? 17'(-v) : v[16:0];
		return t;
	endfunction

	always_comb begin
		tr = 18'(m00) + 18'(m11) + 18'(m22);
		ax = 2'd0;
		if (m11 > m00) ax = 2'd1;
		if (m22 > ((ax == 2'd1) ? m11 : m00)) ax = 2'd2;
		unique case (ax)
			2'd1:    begin mii = m11; mjj = m22; mkk = m00; end
			2'd2:    begin mii = m22; mjj = m00; mkk = m11; end
			default: begin mii = m00; mjj = m11; mkk = m22; end
		endcase
		arg_d = 18'(mii) - 18'(mjj) - 18'(mkk);
		if (tr > 0) begin
			d0 = 18'(m21) - 18'(m12);
			d1 = 18'(m02) - 18'(m20);
			d2 = 18'(m10) - 18'(m01);
		end else begin
			unique case (ax)
				2'd1: begin
					d0 = 18'(m02) - 18'(m20);
					d1 = 18'(m21) + 18'(m12);
					d2 = 18'(m10) + 18'(m01);
				end
				2'd2: begin
					d0 = 18'(m10) - 18'(m01);
					d1 = 18'(m02) + 18'(m20);
					d2 = 18'(m21) + 18'(m12);
				end
				default: begin
					d0 = 18'(m21) - 18'(m12);
					d1 = 18'(m10) + 18'(m01);
					d2 = 18'(m20) + 18'(m02);
				end
			endcase
		end
	end

	tag_t             tag_s1;
	logic [ARG_W-1:0] arg_s1;
	term_t [2:0]      term_s1;
	logic signed [ARG_W-1:0] arg_full;

	always_comb begin
		arg_full = ARG_W'((tr > 0) ? tr : arg_d) + (ARG_W'(1) << FRAC_BITS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else if (adv) begin
			tag_s1.vld    <= in_valid;
			tag_s1.branch <= (tr > 0) ? BR_TRACE
				: (ax == 2'd0) ? BR_AX0 : (ax == 2'd1) ? BR_AX1 : BR_AX2;
			tag_s1.degen  <= !(tr > 0) && (arg_full <= 0);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			arg_s1        <= arg_full;
			term_s1[0]    <= to_term(d0);
			term_s1[1]    <= to_term(d1);
			term_s1[2]    <= to_term(d2);
		end
	end

	// ---------------- square-root cell chain ---------------------------------
	logic [NS:0][RAD_W-1:0]  srem;
	logic [NS:0][ROOT_W-1:0] sroot;
	tag_t        [NS:0]      stag;
	term_t [NS:0][2:0]       sterm;

	assign srem[0]  = RAD_W'(arg_s1[ARG_W-2:0]) << FRAC_BITS;
	assign sroot[0] = '0;
	assign stag[0]  = tag_s1;
	assign sterm[0] = term_s1;

	for (genvar g = 0; g < NS; g++) begin : g_sq
		rmq_sqrt_cell #(.RAD_W(RAD_W), .ROOT_W(ROOT_W), .STEP(g)) u_cell (
			.clk(clk), .en(adv),
			.rem_in(srem[g]), .root_in(sroot[g]),
			.rem_out(srem[g+1]), .root_out(sroot[g+1])
		);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) stag[g+1] <= '0;
			else if (adv) stag[g+1] <= stag[g];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				sterm[g+1]       <= sterm[g];
			end
		end
	end

	// ---------------- divider cell chain -------------------------------------
	// Dividend mag*2^F + R over 2R gives round-half-away directly.
	logic [DEN_W-1:0] rr;
	assign rr = {sroot[NS], 1'b0};

	logic [ND:0][2:0][NUM_W-1:0] drem;
	logic [ND:0][2:0][Q_W-1:0]   dquo;
	logic [ND:0][DEN_W-1:0]      dden;
	logic [ND:0][ROOT_W-1:0]     droot;
	logic [ND:0][2:0]            dneg;
	tag_t [ND:0]                 dtag;

	always_comb begin
		for (int t = 0; t < 3; t++) begin
			drem[0][t] = (NUM_W'(sterm[NS][t].mag) << FRAC_BITS)
				+ NUM_W'(sroot[NS]);
			dneg[0][t] = sterm[NS][t].neg;
		end
	end
	assign dquo[0]  = '0;
	assign dden[0]  = rr;
	assign droot[0] = sroot[NS];
	assign dtag[0]  = stag[NS];

	for (genvar g = 0; g < ND; g++) begin : g_dv
		rmq_div_cell #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(Q_W), .STEP(g)) u_cell (
			.clk(clk), .en(adv), .den(dden[g]),
			.rem_in(drem[g]), .quo_in(dquo[g]),
			.rem_out(drem[g+1]), .quo_out(dquo[g+1])
		);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dtag[g+1] <= '0;
			else if (adv) dtag[g+1] <= dtag[g];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				dden[g+1]        <= dden[g];
				droot[g+1]       <= droot[g];
				dneg[g+1]        <= dneg[g];
			end
		end
	end

	// ---------------- saturation and output register -------------------------
	function automatic logic signed [ELEM_W-1:0] sat_term(input logic neg,
		input logic [Q_W-1:0] q);
		logic signed [ELEM_W-1:0] r;
		if (!neg) r = (q > 18'd32767) ? 16'sd32767 : ELEM_W'(q);
		else r = (q > 18'd32768) ? -16'sd32768 : ELEM_W'(-q);
		return r;
	endfunction

	logic signed [ELEM_W-1:0] half, t0, t1, t2;
	logic signed [ELEM_W-1:0] ow, ox, oy, oz;
	logic [ROOT_W-1:0]        hr;

	always_comb begin
		hr   = droot[ND] >> 1;
		half = (hr > ROOT_W'(32767)) ? 16'sd32767 : ELEM_W'(hr);
		t0   = sat_term(dneg[ND][0], dquo[ND][0]);
		t1   = sat_term(dneg[ND][1], dquo[ND][1]);
		t2   = sat_term(dneg[ND][2], dquo[ND][2]);
		ow = '0; ox = '0; oy = '0; oz = '0;
		if (!dtag[ND].degen) begin
			unique case (dtag[ND].branch)
				BR_TRACE: begin ow = half; ox = t0; oy = t1; oz = t2; end
				BR_AX0:   begin ox = half; ow = t0; oy = t1; oz = t2; end
				BR_AX1:   begin oy = half; ow = t0; oz = t1; ox = t2; end
				default:  begin oz = half; ow = t0; ox = t1; oy = t2; end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (adv) out_valid <= dtag[ND].vld;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			qw         <= ow;
			qx         <= ox;
			qy         <= oy;
			qz         <= oz;
			branch     <= dtag[ND].branch;
			degenerate <= dtag[ND].degen;
		end
	end

	// A degenerate result is all zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> qw == 0 && qx == 0 && qy == 0 && qz == 0)
		else $error("degenerate result not zero");
	// The trace path never reports degenerate.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && branch == BR_TRACE |-> !degenerate)
		else $error("trace path flagged degenerate");
	// A held output keeps its contents.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(qw) && $stable(branch))
		else $error("stalled result changed");
endmodule

[bench/tb_rotation_matrix_to_quaternion_unit.sv]
// ----------------------------------------------------------------------------
// tb_rotation_matrix_to_quaternion_unit: matrix-to-quaternion pipeline bench
// Drives matrices through the valid/stall input, predicts each quaternion,
// branch and degenerate flag in fixed point, and checks results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_rotation_matrix_to_quaternion_unit;
	import rmq_pkg::*;

	localparam int FRAC_BITS = 14;
	// input register, 17 root cells, 18 divider cells, output register
	localparam int LATENCY   = 1 + 17 + 18 + 1;
	localparam int ONE       = 1 << FRAC_BITS;

	typedef logic signed [ELEM_W-1:0] elem_t;

	typedef struct {
		elem_t       w, x, y, z;
		logic [1:0]  br;
		logic        degen;
	} quat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	elem_t m00 = '0, m01 = '0, m02 = '0, m10 = '0, m11 = '0, m12 = '0;
	elem_t m20 = '0, m21 = '0, m22 = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	elem_t qw, qx, qy, qz;
	logic [1:0] branch;
	logic degenerate;

	quat_t pending_quats[$];
	int    mismatches = 0;
	int    idle_pct = 28;     // shared idling rate, both sides
	int    hold_cycles = 0;   // long receiver hold-off request

	rotation_matrix_to_quaternion_unit #(.FRAC_BITS(FRAC_BITS)) dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic elem_t clamp16(longint v);
		if (v > 32767) return 16'sh7fff;
		if (v < -32768) return 16'sh8000;
		return elem_t'(v);
	endfunction

	// d * 2^F / (2r), rounded half away from zero
	function automatic elem_t scale_by_root(longint d, longint unsigned r);
		longint unsigned mag, q;
		mag = longint'(d < 0 ? -d : d) << FRAC_BITS;
		q = (mag + r) / (2 * r);
		if (q > 65536) q = 65536;
		return clamp16(d < 0 ? -longint'(q) : longint'(q));
	endfunction

	function automatic quat_t matrix_to_quat(elem_t e[9]);
		longint m[3][3];
		longint c[4];
		longint tr, arg;
		longint unsigned r;
		int i, j, k;
		quat_t q;
		for (int a = 0; a < 9; a++) m[a/3][a%3] = e[a];
		c = '{0, 0, 0, 0};
		q.degen = 1'b0;
		tr = m[0][0] + m[1][1] + m[2][2];
		if (tr > 0) begin
			q.br = BR_TRACE;
			r = int_sqrt(longint'(tr + ONE) << FRAC_BITS);
			c[0] = longint'(r >> 1);
			c[1] = scale_by_root(m[2][1] - m[1][2], r);
			c[2] = scale_by_root(m[0][2] - m[2][0], r);
			c[3] = scale_by_root(m[1][0] - m[0][1], r);
		end else begin
			i = 0;
			if (m[1][1] > m[0][0]) i = 1;
			if (m[2][2] > m[i][i]) i = 2;   // ties keep the lower axis
			j = (i + 1) % 3;
			k = (j + 1) % 3;
			q.br = (i == 0) ? BR_AX0 : (i == 1) ? BR_AX1 : BR_AX2;
			arg = m[i][i] - m[j][j] - m[k][k] + ONE;
			if (arg <= 0) begin
				q.degen = 1'b1;
			end else begin
				r = int_sqrt(longint'(arg) << FRAC_BITS);
				c[1+i] = longint'(r >> 1);
				c[0]   = scale_by_root(m[k][j] - m[j][k], r);
				c[1+j] = scale_by_root(m[j][i] + m[i][j], r);
				c[1+k] = scale_by_root(m[k][i] + m[i][k], r);
			end
		end
		q.w = clamp16(c[0]);
		q.x = clamp16(c[1]);
		q.y = clamp16(c[2]);
		q.z = clamp16(c[3]);
		return q;
	endfunction

	// ------------------------------------------------------------------
	// Sender: one matrix per transfer, random gaps
	// ------------------------------------------------------------------
	task automatic send_matrix(elem_t e[9]);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		{m00, m01, m02, m10, m11, m12, m20, m21, m22} <=
			{e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_quats.push_back(matrix_to_quat(e));
		@(negedge clk);
	endtask

	// Drop valid after a burst of transfers
	task automatic idle_input();
		in_valid <= 1'b0;
		@(negedge clk);
	endtask

	function automatic elem_t rand_elem();
		case ($urandom_range(5))
			0: return elem_t'($urandom);
			1: return 16'sh7fff;
			2: return 16'sh8000;
			3: return elem_t'($urandom_range(2 * ONE) - ONE);
			default: return elem_t'($urandom_range(ONE / 2) - ONE / 4);
		endcase
	endfunction

	// Near-rotation: small off-diagonals; one random dominant diagonal, or three positive
	function automatic void near_rotation(ref elem_t e[9]);
		int ax;
		ax = $urandom_range(3);
		for (int a = 0; a < 9; a++) e[a] = elem_t'($urandom_range(ONE) - ONE / 2);
		for (int a = 0; a < 3; a++) begin
			if (ax == 3) e[a*4] = elem_t'($urandom_range(ONE / 2) + ONE / 4);
			else if (a == ax) e[a*4] = elem_t'($urandom_range(ONE / 2) + ONE / 2);
			else e[a*4] = elem_t'(-$urandom_range(ONE) );
		end
	endfunction

	// ------------------------------------------------------------------
	// Receiver: random stalls plus an optional long hold-off
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else begin
			out_stall <= ($urandom_range(99) < idle_pct);
		end
	end

	// Checker: compare each accepted result with the oldest prediction
	always @(posedge clk) begin
		quat_t exp_q;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_quats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected result w=%0d x=%0d y=%0d z=%0d",
						qw, qx, qy, qz);
			end else begin
				exp_q = pending_quats.pop_front();
				if (qw !== exp_q.w || qx !== exp_q.x || qy !== exp_q.y ||
						qz !== exp_q.z || branch !== exp_q.br ||
						degenerate !== exp_q.degen) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: exp w=%0d x=%0d y=%0d z=%0d br=%0d dg=%0d",
							exp_q.w, exp_q.x, exp_q.y, exp_q.z, exp_q.br, exp_q.degen,
							" got w=%0d x=%0d y=%0d z=%0d br=%0d dg=%0d",
							qw, qx, qy, qz, branch, degenerate);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	task automatic wait_drained();
		while (pending_quats.size() != 0) @(negedge clk);
	endtask

	// Extremes, each branch, ties and full-scale terms
	task automatic test_directed();
		elem_t e[9];
		e = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};                       send_matrix(e);
		e = '{ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE};                     send_matrix(e);
		e = '{-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE};                     send_matrix(e);
		e = '{-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE};                     send_matrix(e);
		e = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                             send_matrix(e); // three-way tie
		e = '{-ONE, 5, 7, 3, -ONE, 2, 1, 9, -ONE/2};                  send_matrix(e);
		e = '{-100, 0, 0, 0, -100, 0, 0, 0, -200};                    send_matrix(e); // tie 0/1
		e = '{-32768, 1, 2, 3, 32767, 4, 5, 6, 32767};                send_matrix(e); // trace path, extreme diagonals
		e = '{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768};              send_matrix(e);
		e = '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767}; send_matrix(e);
		e = '{1, 32767, -32768, -32768, 0, 32767, 32767, -32768, 0};  send_matrix(e); // negative full scale
		e = '{-32768, 32767, 32767, 32767, -32768, 32767, 32767, 32767, -32768};
		send_matrix(e);
		e = '{-8000, -32768, -32768, -32768, 8000, -32768, -32768, -32768, -32768};
		send_matrix(e);
		e = '{1, 0, 0, 0, 0, 0, 0, 0, 0};                             send_matrix(e);
		e = '{-1, 0, 0, 0, -1, 0, 0, 0, 1};                           send_matrix(e);
		e = '{-ONE, 0, 0, 0, 0, 0, 0, 0, -ONE+1};                     send_matrix(e);
		e = '{16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555,
			16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555};              send_matrix(e);
		e = '{16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa,
			16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa};              send_matrix(e);
		idle_input();
	endtask

	task automatic test_random(int count);
		elem_t e[9];
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(99) < 65) near_rotation(e);
			else foreach (e[a]) e[a] = rand_elem();
			send_matrix(e);
		end
		idle_input();
	endtask

	// Receiver holds off long enough that the pipeline fills and stalls input
	task automatic test_backpressure();
		elem_t e[9];
		hold_cycles = 3 * LATENCY;
		for (int n = 0; n < 2 * LATENCY; n++) begin
			near_rotation(e);
			send_matrix(e);
		end
		idle_input();
	endtask

	// No idling on either side: full-rate streaming
	task automatic test_streaming();
		idle_pct = 0;
		test_random(150);
		idle_pct = 28;
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		wait_drained();      // sender pauses until all results are back
		test_random(300);
		test_backpressure();
		test_streaming();
		test_random(200);
		wait_drained();
		repeat (LATENCY + 10) @(posedge clk);
		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#5ms;
		$display("Test completed with failures");
		$finish;
	end

endmodule
